FILE: sv/wrrt_pkg.sv
package wrrt_pkg;

   // Sequence space, window and time widths.
   localparam int SEQ_SLOTS  = 64;
   localparam int SLOT_W     = $clog2(SEQ_SLOTS);
   localparam int MAX_WINDOW = 16;
   localparam int WIN_W      = 5;
   localparam int TIME_BITS  = 32;
   localparam int RETRY_W    = 5;
   localparam int FUNC_W     = 2;
   localparam int KIND_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // One memory word per slot: retry count above the next due time.
   localparam int RAM_W = RETRY_W + TIME_BITS;

   localparam logic [TIME_BITS-1:0] TIME_MAX     = '1;
   localparam logic [RETRY_W-1:0]   RETRY_MAX    = '1;
   localparam logic [WIN_W-1:0]     WINDOW_LIMIT = WIN_W'(MAX_WINDOW);

   localparam logic [WIN_W-1:0]     RESET_WINDOW = WIN_W'(4);
   localparam logic [TIME_BITS-1:0] RESET_RTO    = TIME_BITS'(3000000);
   localparam logic [TIME_BITS-1:0] RESET_RTTVAR = TIME_BITS'(750000);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SUBMIT = 2'd0,
      FUNC_ACK    = 2'd1,
      FUNC_TICK   = 2'd2
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPTED = 3'd0,
      KIND_FULL     = 3'd1,
      KIND_NEW_ACK  = 3'd2,
      KIND_DUP_ACK  = 3'd3,
      KIND_RESEND   = 3'd4,
      KIND_NOTHING  = 3'd5
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_SIZE    = 2'd0,
      CSR_INITIAL_RTO    = 2'd1,
      CSR_INITIAL_RTTVAR = 2'd2
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic submit;
      logic ack_dup;
      logic rtt_diff;
      logic rtt_srtt;
      logic rtt_var;
      logic rtt_rto;
      logic walk_step;
      logic ack_done;
      logic scan_read;
      logic scan_eval;
      logic scan_write;
      logic scan_finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ack_dup;
      logic walk_done;
      logic scan_more;
      logic scan_due;
   } status_type;

endpackage

FILE: sv/wrrt_ram.sv
module wrrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/wrrt_ctrl.sv
module wrrt_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [wrrt_pkg::FUNC_W-1:0]  req_func,
   input  wrrt_pkg::status_type         status,
   output wrrt_pkg::cmd_type            cmd,
   output logic                         busy
);

   import wrrt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUBMIT,
      ST_ACK_CHK,
      ST_RTT_DIFF,
      ST_RTT_SRTT,
      ST_RTT_VAR,
      ST_RTT_RTO,
      ST_WALK,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_SCAN_WR
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (func_type'(req_func))
                  FUNC_SUBMIT: state_in = ST_SUBMIT;
                  FUNC_ACK:    state_in = ST_ACK_CHK;
                  FUNC_TICK:   state_in = ST_SCAN_RD;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_SUBMIT: begin
            cmd.submit = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_ACK_CHK: begin
            if (status.ack_dup) begin
               cmd.ack_dup = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_RTT_DIFF;
            end
         end
         ST_RTT_DIFF: begin
            cmd.rtt_diff = 1'b1;
            state_in     = ST_RTT_SRTT;
         end
         ST_RTT_SRTT: begin
            cmd.rtt_srtt = 1'b1;
            state_in     = ST_RTT_VAR;
         end
         ST_RTT_VAR: begin
            cmd.rtt_var = 1'b1;
            state_in    = ST_RTT_RTO;
         end
         ST_RTT_RTO: begin
            cmd.rtt_rto = 1'b1;
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            if (status.walk_done) begin
               cmd.ack_done = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_SCAN_RD: begin
            if (status.scan_more) begin
               cmd.scan_read = 1'b1;
               state_in      = ST_SCAN_EV;
            end else begin
               cmd.scan_finish = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_SCAN_EV: begin
            cmd.scan_eval = 1'b1;
            state_in      = status.scan_due ? ST_SCAN_WR : ST_SCAN_RD;
         end
         ST_SCAN_WR: begin
            cmd.scan_write = 1'b1;
            state_in       = ST_SCAN_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

FILE: sv/wrrt_dp.sv
module wrrt_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  wrrt_pkg::cmd_type                cmd,
   output wrrt_pkg::status_type             status,
   input  logic [wrrt_pkg::SLOT_W-1:0]      req_seq,
   input  logic [wrrt_pkg::TIME_BITS-1:0]   req_echo_time,
   input  logic [wrrt_pkg::TIME_BITS-1:0]   req_now,
   input  logic                             csr_we,
   input  logic [wrrt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wrrt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                             rsp_valid,
   output logic [wrrt_pkg::KIND_W-1:0]      rsp_kind,
   output logic [wrrt_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [wrrt_pkg::TIME_BITS-1:0]   rsp_rto,
   output logic                             rsp_last
);

   import wrrt_pkg::*;

   // Window bookkeeping and estimator state.
   logic [SLOT_W-1:0]    head_ff;
   logic [SLOT_W-1:0]    tail_ff;
   logic [SEQ_SLOTS-1:0] acked_ff;
   logic [WIN_W-1:0]     window_ff;
   logic [TIME_BITS-1:0] srtt_ff;
   logic [TIME_BITS-1:0] rttvar_ff;
   logic [TIME_BITS-1:0] rto_ff;

   // Latched request and working registers.
   logic [SLOT_W-1:0]    seq_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [TIME_BITS-1:0] sample_ff;
   logic [TIME_BITS-1:0] d_ff;
   logic                 srtt_ge_ff;
   logic [TIME_BITS-1:0] e_ff;
   logic                 var_ge_ff;
   logic [SLOT_W-1:0]    scan_idx_ff;
   logic [SLOT_W-1:0]    scan_slot_ff;
   logic [TIME_BITS-1:0] backoff_ff;
   logic [RETRY_W-1:0]   retry_next_ff;
   logic                 pend_valid_ff;
   logic [SLOT_W-1:0]    pend_slot_ff;

   // Result register.
   logic                 rsp_valid_ff;
   kind_type             rsp_kind_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [TIME_BITS-1:0] rsp_rto_ff;
   logic                 rsp_last_ff;

   // Combinational terms.
   logic [SLOT_W-1:0]    outstanding;
   logic [WIN_W-1:0]     win_eff;
   logic [WIN_W-1:0]     win_lim;
   logic                 can_submit;
   logic [SLOT_W-1:0]    ack_off;
   logic [TIME_BITS:0]   srtt_diff;
   logic [TIME_BITS-1:0] d_in;
   logic [TIME_BITS:0]   var_diff;
   logic [TIME_BITS-1:0] e_in;
   logic [TIME_BITS-1:0] srtt_in;
   logic [TIME_BITS-1:0] rttvar_in;
   logic [TIME_BITS:0]   rto_sum;
   logic [TIME_BITS-1:0] rto_in;
   logic [SLOT_W-1:0]    scan_addr;
   logic [RETRY_W-1:0]   retry_rd;
   logic [TIME_BITS-1:0] due_rd;
   logic [TIME_BITS-1:0] backoff_in;
   logic [RETRY_W-1:0]   retry_next_in;
   logic [TIME_BITS:0]   due_sum;
   logic [TIME_BITS-1:0] due_in;
   logic                 ram_we;
   logic [SLOT_W-1:0]    ram_waddr;
   logic [RAM_W-1:0]     ram_wdata;
   logic [RAM_W-1:0]     ram_rdata;

   assign outstanding = tail_ff - head_ff;
   assign win_eff     = (window_ff > WINDOW_LIMIT) ? WINDOW_LIMIT : window_ff;
   assign win_lim     = (win_eff == '0) ? '0 : win_eff - WIN_W'(1);
   assign can_submit  = ({1'b0, outstanding} < {{(SLOT_W + 1 - WIN_W){1'b0}}, win_lim});
   assign ack_off     = seq_ff - head_ff;

   // Round-trip estimator, one add or subtract level per step.
   assign srtt_diff = {1'b0, sample_ff} - {1'b0, srtt_ff};
   assign d_in      = srtt_diff[TIME_BITS] ? (srtt_ff - sample_ff) : srtt_diff[TIME_BITS-1:0];
   assign srtt_in   = srtt_ge_ff ? (srtt_ff + (d_ff >> 3)) : (srtt_ff - (d_ff >> 3));
   assign var_diff  = {1'b0, d_ff} - {1'b0, rttvar_ff};
   assign e_in      = var_diff[TIME_BITS] ? (rttvar_ff - d_ff) : var_diff[TIME_BITS-1:0];
   assign rttvar_in = var_ge_ff ? (rttvar_ff + (e_ff >> 2)) : (rttvar_ff - (e_ff >> 2));
   assign rto_sum   = {1'b0, srtt_ff} + {1'b0, rttvar_ff << 2};
   assign rto_in    = ((rttvar_ff > (TIME_MAX >> 2)) || rto_sum[TIME_BITS]) ?
                      TIME_MAX : rto_sum[TIME_BITS-1:0];

   // Timer scan.
   assign scan_addr     = head_ff + scan_idx_ff;
   assign retry_rd      = ram_rdata[RAM_W-1 -: RETRY_W];
   assign due_rd        = ram_rdata[TIME_BITS-1:0];
   assign backoff_in    = (rto_ff > (TIME_MAX >> retry_rd)) ? TIME_MAX : (rto_ff << retry_rd);
   assign retry_next_in = (retry_rd == RETRY_MAX) ? RETRY_MAX : retry_rd + RETRY_W'(1);
   assign due_sum       = {1'b0, now_ff} + {1'b0, backoff_ff};
   assign due_in        = due_sum[TIME_BITS] ? TIME_MAX : due_sum[TIME_BITS-1:0];

   assign ram_we    = (cmd.submit && can_submit) || cmd.scan_write;
   assign ram_waddr = cmd.submit ? tail_ff : scan_slot_ff;
   assign ram_wdata = cmd.submit ? '0 : {retry_next_ff, due_in};

   wrrt_ram #(
      .WIDTH (RAM_W),
      .DEPTH (SEQ_SLOTS)
   ) u_timer_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (scan_addr),
      .rdata (ram_rdata)
   );

   assign status.ack_dup   = (ack_off >= outstanding) || acked_ff[seq_ff];
   assign status.walk_done = (head_ff == tail_ff) || !acked_ff[head_ff];
   assign status.scan_more = (scan_idx_ff < outstanding);
   assign status.scan_due  = !acked_ff[scan_slot_ff] && (now_ff > due_rd);

   // Control state and estimator registers with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         acked_ff      <= '0;
         window_ff     <= RESET_WINDOW;
         srtt_ff       <= '0;
         rttvar_ff     <= RESET_RTTVAR;
         rto_ff        <= RESET_RTO;
         scan_idx_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (cmd.capture) begin
            scan_idx_ff   <= '0;
            pend_valid_ff <= 1'b0;
         end
         if (cmd.submit) begin
            rsp_valid_ff <= 1'b1;
            if (can_submit) begin
               acked_ff[tail_ff] <= 1'b0;
               tail_ff           <= tail_ff + SLOT_W'(1);
            end
         end
         if (cmd.ack_dup || cmd.ack_done || cmd.scan_finish) begin
            rsp_valid_ff <= 1'b1;
         end
         if (cmd.rtt_diff) begin
            acked_ff[seq_ff] <= 1'b1;
         end
         if (cmd.rtt_srtt) begin
            srtt_ff <= srtt_in;
         end
         if (cmd.rtt_var) begin
            rttvar_ff <= rttvar_in;
         end
         if (cmd.rtt_rto) begin
            rto_ff <= rto_in;
         end
         if (cmd.walk_step) begin
            head_ff <= head_ff + SLOT_W'(1);
         end
         if ((cmd.scan_eval && !status.scan_due) || cmd.scan_write) begin
            scan_idx_ff <= scan_idx_ff + SLOT_W'(1);
         end
         if (cmd.scan_write) begin
            // The previous due slot goes out now; this one waits to learn
            // whether it is the last of the tick.
            rsp_valid_ff  <= pend_valid_ff;
            pend_valid_ff <= 1'b1;
         end
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_WINDOW_SIZE:    window_ff <= csr_wdata[WIN_W-1:0];
               CSR_INITIAL_RTO:    rto_ff    <= csr_wdata[TIME_BITS-1:0];
               CSR_INITIAL_RTTVAR: rttvar_ff <= csr_wdata[TIME_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seq_ff    <= req_seq;
         now_ff    <= req_now;
         sample_ff <= req_now - req_echo_time;
      end
      if (cmd.rtt_diff) begin
         d_ff       <= d_in;
         srtt_ge_ff <= !srtt_diff[TIME_BITS];
      end
      if (cmd.rtt_srtt) begin
         e_ff      <= e_in;
         var_ge_ff <= !var_diff[TIME_BITS];
      end
      if (cmd.scan_read) begin
         scan_slot_ff <= scan_addr;
      end
      if (cmd.scan_eval) begin
         backoff_ff    <= backoff_in;
         retry_next_ff <= retry_next_in;
      end
      if (cmd.scan_write) begin
         pend_slot_ff <= scan_slot_ff;
      end

      rsp_rto_ff <= rto_ff;
      if (cmd.submit) begin
         rsp_kind_ff <= can_submit ? KIND_ACCEPTED : KIND_FULL;
         rsp_slot_ff <= tail_ff;
         rsp_last_ff <= 1'b1;
      end else if (cmd.ack_dup) begin
         rsp_kind_ff <= KIND_DUP_ACK;
         rsp_slot_ff <= seq_ff;
         rsp_last_ff <= 1'b1;
      end else if (cmd.ack_done) begin
         rsp_kind_ff <= KIND_NEW_ACK;
         rsp_slot_ff <= seq_ff;
         rsp_last_ff <= 1'b1;
      end else if (cmd.scan_write) begin
         rsp_kind_ff <= KIND_RESEND;
         rsp_slot_ff <= pend_slot_ff;
         rsp_last_ff <= 1'b0;
      end else if (cmd.scan_finish) begin
         rsp_kind_ff <= pend_valid_ff ? KIND_RESEND : KIND_NOTHING;
         rsp_slot_ff <= pend_valid_ff ? pend_slot_ff : '0;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign rsp_rto   = rsp_rto_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

FILE: sv/window_retransmit_rto_tracker.sv
// Sender-side window and retransmission timer bookkeeping.
// A request is taken at a rising edge with start high and busy low; req_func
// selects submit, acknowledgement or timer tick, and func code 3 is dropped
// without any response. Responses appear on the rsp_ ports for one cycle each,
// flagged by rsp_valid, with rsp_last on the final response of a request.
// The receiver cannot stall: every response is taken in the cycle it shows.
// A submit answers from ST_SUBMIT. A duplicate or out-of-window acknowledgement
// answers from ST_ACK_CHK; a new one runs ST_RTT_DIFF, ST_RTT_SRTT, ST_RTT_VAR
// and ST_RTT_RTO, then ST_WALK moves the window head past each acknowledged
// slot. A tick reads and evaluates each outstanding slot, writes back each due
// one, and then closes; its last response follows that. The sequencer steps
// through the per-slot timer memory with at most one request in flight, and
// busy falls in the cycle the last response of a request is shown.
// The csr_ port writes window size, initial timeout and initial variance,
// and is meant to be used only while busy is low.
// Synchronous reset empties the window, clears all ack marks and loads the
// default window of four, timeout and variance; no clearing pass is needed.
module window_retransmit_rto_tracker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [wrrt_pkg::FUNC_W-1:0]      req_func,
   input  logic [wrrt_pkg::SLOT_W-1:0]      req_seq,
   input  logic [wrrt_pkg::TIME_BITS-1:0]   req_echo_time,
   input  logic [wrrt_pkg::TIME_BITS-1:0]   req_now,
   output logic                             rsp_valid,
   output logic [wrrt_pkg::KIND_W-1:0]      rsp_kind,
   output logic [wrrt_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [wrrt_pkg::TIME_BITS-1:0]   rsp_rto,
   output logic                             rsp_last,
   input  logic                             csr_we,
   input  logic [wrrt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wrrt_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import wrrt_pkg::*;

   // The controller sequences each request; the datapath holds the window,
   // the estimator and the per-slot timer memory.
   cmd_type    cmd;
   status_type status;

   wrrt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   wrrt_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_seq       (req_seq),
      .req_echo_time (req_echo_time),
      .req_now       (req_now),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_slot      (rsp_slot),
      .rsp_rto       (rsp_rto),
      .rsp_last      (rsp_last)
   );

endmodule
